@@ rtl/latt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latt_pkg: shared types and constants of the aging transposition table
// Operation codes, payload structs and default sizing.
// ----------------------------------------------------------------------------
package latt_pkg;

    localparam int ENTRIES_DEF      = 4096;
    localparam int SAMPLE_COUNT_DEF = 1000;
    localparam int MATE_BOUND_DEF   = 30000;
    localparam int PLY_LIMIT_DEF    = 128;

    localparam int KEY_W     = 64;
    localparam int DATA_W    = 64;
    localparam int WORD_W    = KEY_W + DATA_W;
    localparam int AGE_W     = 4;
    localparam int USAGE_W   = 10;
    localparam int USAGE_MAX = 1023;

    localparam logic [2:0] OP_SAVE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_NEWIT = 3'd3;
    localparam logic [2:0] OP_USAGE = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [KEY_W-1:0]  key;
        logic signed [7:0] search_depth;
        logic [7:0]        ply;
        logic signed [15:0] value_score;
        logic signed [15:0] eval_score;
        logic [15:0]       best_move;
        logic [3:0]        bound_flag;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] out_score;
        logic signed [15:0] out_eval;
        logic [15:0]        out_move;
        logic signed [7:0]  out_depth;
        logic [3:0]         out_flag;
        logic [USAGE_W-1:0] usage_count;
    } rsp_t;

    // Outcome of one entry evaluation for save or load
    typedef struct packed {
        logic              replace;
        logic [WORD_W-1:0] word;
        rsp_t              rsp;
    } entry_out_t;

endpackage

@@ rtl/latt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module latt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/latt_entry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latt_entry: entry check, replacement decision and mate score shift
// Evaluates one stored word against a save or load request.
// ----------------------------------------------------------------------------
module latt_entry #(
    parameter int MATE_BOUND = latt_pkg::MATE_BOUND_DEF,
    parameter int PLY_LIMIT  = latt_pkg::PLY_LIMIT_DEF
) (
    input  latt_pkg::req_t                   req,
    input  logic [latt_pkg::WORD_W-1:0]      stored,
    input  logic [latt_pkg::AGE_W-1:0]       age,
    output latt_pkg::entry_out_t             result
);
    import latt_pkg::*;

    localparam logic signed [16:0] BOUND = 17'(MATE_BOUND - PLY_LIMIT);

    logic [KEY_W-1:0]   chk;
    logic [DATA_W-1:0]  data;
    logic               match;
    logic signed [15:0] st_score;
    logic signed [7:0]  st_depth;
    logic [15:0]        ply16;
    logic [15:0]        save_score;
    logic [15:0]        load_score;
    logic [DATA_W-1:0]  new_data;

    assign chk      = stored[WORD_W-1:DATA_W];
    assign data     = stored[DATA_W-1:0];
    assign match    = (chk ^ req.key) == data;
    assign st_score = data[15:0];
    assign st_depth = data[55:48];
    assign ply16    = {8'd0, req.ply};

    always_comb
    begin
        if (req.value_score > BOUND)
            save_score = 16'(req.value_score + ply16);
        else if (req.value_score < -BOUND)
            save_score = 16'(req.value_score - ply16);
        else
            save_score = req.value_score;

        if (st_score > BOUND)
            load_score = 16'(st_score - ply16);
        else if (st_score < -BOUND)
            load_score = 16'(st_score + ply16);
        else
            load_score = st_score;
    end

    assign new_data = {age, req.bound_flag, req.search_depth, req.best_move,
                       req.eval_score, save_score};

    always_comb
    begin
        result.replace = match || (req.search_depth >= st_depth)
                         || (data[63:60] != age);
        result.word    = {req.key ^ new_data, new_data};
        result.rsp     = '0;
        if (match)
        begin
            result.rsp.hit       = 1'b1;
            result.rsp.out_score = load_score;
            result.rsp.out_eval  = data[31:16];
            result.rsp.out_move  = data[47:32];
            result.rsp.out_depth = st_depth;
            result.rsp.out_flag  = data[59:56];
        end
    end

endmodule

@@ rtl/lockless_aging_transposition_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockless_aging_transposition_table: direct-mapped lockless hash table
// Depth-preferred, age-aware replacement with XOR-checked entries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the command transfers at a rising edge
//   with start high and busy low. Every command yields one result on the
//   result port, marked by done for exactly one cycle; the receiver cannot
//   stall, so it must take the result in that cycle.
//   Command sequences:
//     save, load     read the entry, then check it and, for a save, write back
//                    if it replaces; done the cycle after the evaluation, a new
//                    command may transfer in that same cycle.
//     new iteration  done the cycle after the transfer, also any unknown op code.
//     clear          one memory row written per cycle.
//     usage          one row read per cycle over the read port of the table memory.
//   Reset: the table memory is swept to zero after reset is released; busy
//   stays high and no result appears during that pass.
//   ENTRIES must be a power of two: the low key bits select the entry.
// ----------------------------------------------------------------------------
module lockless_aging_transposition_table #(
    parameter int ENTRIES      = latt_pkg::ENTRIES_DEF,
    parameter int SAMPLE_COUNT = latt_pkg::SAMPLE_COUNT_DEF,
    parameter int MATE_BOUND   = latt_pkg::MATE_BOUND_DEF,
    parameter int PLY_LIMIT    = latt_pkg::PLY_LIMIT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  latt_pkg::req_t request,
    output logic           done,
    output latt_pkg::rsp_t result
);
    import latt_pkg::*;

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int WALK_W = $clog2(ENTRIES + 1);
    localparam int N_SAMP = (SAMPLE_COUNT < ENTRIES) ? SAMPLE_COUNT : ENTRIES;
    localparam int CNT_W  = $clog2(N_SAMP + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_INIT  = 3'd3;
    localparam logic [2:0] ST_USAGE = 3'd4;

    logic [2:0]        state_reg;
    logic [WALK_W-1:0] walk_reg;
    logic [AGE_W-1:0]  age_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              done_reg;
    rsp_t              result_reg;
    req_t              req_reg;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    entry_out_t        entry;
    logic              age_match;
    logic [CNT_W-1:0]  count_total;
    logic [10:0]       total11;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    latt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    latt_entry #(
        .MATE_BOUND (MATE_BOUND),
        .PLY_LIMIT  (PLY_LIMIT)
    ) u_entry (
        .req    (req_reg),
        .stored (ram_rdata),
        .age    (age_reg),
        .result (entry)
    );

    assign ram_raddr = (state_reg == ST_USAGE) ? walk_reg[ADDR_W-1:0]
                                               : request.key[ADDR_W-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = req_reg.key[ADDR_W-1:0];
        ram_wdata = entry.word;
        case (state_reg)
            ST_EXEC:
            begin
                ram_we = (req_reg.op == OP_SAVE) && entry.replace;
            end
            ST_CLEAR, ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = walk_reg[ADDR_W-1:0];
                ram_wdata = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Row read in the previous cycle counts once the walk has started
    assign age_match   = (walk_reg != '0) && (ram_rdata[DATA_W-1 -: AGE_W] == age_reg);
    assign count_total = count_reg + CNT_W'(age_match);
    assign total11     = 11'(count_total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            walk_reg  <= '0;
            age_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        walk_reg  <= '0;
                        count_reg <= '0;
                        case (request.op)
                            OP_SAVE, OP_LOAD: state_reg <= ST_EXEC;
                            OP_CLEAR:         state_reg <= ST_CLEAR;
                            OP_USAGE:         state_reg <= ST_USAGE;
                            OP_NEWIT:
                            begin
                                age_reg  <= age_reg + 1'b1;
                                done_reg <= 1'b1;
                            end
                            default:          done_reg  <= 1'b1;
                        endcase
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                end
                ST_CLEAR, ST_INIT:
                begin
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_reg == WALK_W'(ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                        age_reg   <= '0;
                        done_reg  <= state_reg == ST_CLEAR;
                    end
                end
                ST_USAGE:
                begin
                    count_reg <= count_total;
                    walk_reg  <= walk_reg + 1'b1;
                    if (walk_reg == WALK_W'(N_SAMP))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Other result fields stay zero from the transfer of the usage command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= request;
            result_reg <= '0;
        end
        else if (state_reg == ST_EXEC)
        begin
            result_reg <= (req_reg.op == OP_LOAD) ? entry.rsp : '0;
        end
        else if (state_reg == ST_USAGE && walk_reg == WALK_W'(N_SAMP))
        begin
            result_reg.usage_count <= (total11 > 11'(USAGE_MAX)) ? USAGE_W'(USAGE_MAX)
                                                                 : total11[USAGE_W-1:0];
        end
        else if (state_reg == ST_CLEAR)
        begin
            result_reg <= '0;
        end
    end

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a command");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC || state_reg == ST_CLEAR
                    || state_reg == ST_INIT))
        else $error("table write outside save or clear");

    a_rmw_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.op == OP_SAVE || request.op == OP_LOAD))
        |=> state_reg == ST_EXEC)
        else $error("save or load did not go to evaluation");

    a_hit_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && req_reg.op != OP_LOAD) |-> !result.hit)
        else $error("hit reported for a non-load command");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg <= WALK_W'(ENTRIES))
        else $error("walk counter beyond table");

endmodule
